// ===== src/assert_macros.svh =====
// Concurrent assertion helpers, clocked on a rising edge and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at an edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/blis_pkg.sv =====
package blis_pkg;

	localparam int CAPACITY_DEF   = 32;
	localparam int WORD_WIDTH_DEF = 32;

	// Common width for comparing slice bounds against the fill count.
	localparam int CMP_W = 7;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SLICE  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_DUP   = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] word;
		logic [5:0]  slice_start;
		logic [5:0]  slice_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] out_word;
		logic [5:0]  out_index;
		logic        word_valid;
		logic [5:0]  removed_count;
		logic [5:0]  fill_count;
		logic        last;
	} out_item_t;

endpackage

// ===== src/blis_ram.sv =====
module blis_ram import blis_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int WIDTH = WORD_WIDTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/bounded_list_insert_remove_slice.sv =====
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_wen              cfg_wdata (allow_duplicates)
// in        in         in_valid / in_stall  in_data   (in_item_t)
// out       out        out_valid / out_stall out_data (out_item_t)
//
// Insert with duplicates allowed or a full list: the result is registered, then loaded into the output.
// Duplicate-checked insert and remove: a scan over the held entries, one entry
// per cycle through the single read port of the entry RAM and one shared comparator.
// Slice of n entries: one entry per cycle from the same read port while out is not stalled.
// Reset clears the fill count and state; entries are not cleared.
// A stalled output holds the sequencer; in_stall is high until the last result is loaded.
`include "assert_macros.svh"

module bounded_list_insert_remove_slice import blis_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wen,
	input  logic      cfg_wdata,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_FIN    = 5'b00100,
		S_SL_RD  = 5'b01000,
		S_SL_OUT = 5'b10000
	} state_t;

	state_t                state_q, state_d;
	logic                  allow_q;
	logic [CNT_W-1:0]      held_q, held_d;
	logic [CNT_W-1:0]      i_q, i_d;
	logic [CNT_W-1:0]      e_q, e_d;
	logic [CNT_W-1:0]      kept_q, kept_d;
	logic [CNT_W-1:0]      removed_q, removed_d;
	logic                  pv_q, pv_d;
	logic [1:0]            op_q, op_d;
	logic [WORD_WIDTH-1:0] w_q, w_d;
	out_item_t             res_q, res_d;
	out_item_t             out_q, load_data;
	logic                  out_valid_q;
	logic                  load_out;

	logic                  rd_en, wr_en;
	logic [IDX_W-1:0]      rd_addr, wr_addr;
	logic [WORD_WIDTH-1:0] wr_data, rdata;
	logic [63:0]           rd_wide;
	logic [WORD_WIDTH-1:0] w_in;
	logic [CMP_W-1:0]      s_ext, e_ext, held_ext, e_clamp;
	logic [CNT_W-1:0]      i_nxt;
	logic                  hit, out_free;

	blis_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (WORD_WIDTH),
		.AW    (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rdata)
	);

	assign w_in     = WORD_WIDTH'(in_data.word);
	assign rd_wide  = 64'(rdata);
	assign s_ext    = CMP_W'(in_data.slice_start);
	assign e_ext    = CMP_W'(in_data.slice_end);
	assign held_ext = CMP_W'(held_q);
	// Clamp the end to the last held entry; only used when start is below held.
	assign e_clamp  = (e_ext > held_ext - 1'b1) ? held_ext - 1'b1 : e_ext;
	assign i_nxt    = i_q + 1'b1;
	// Shared comparator: the entry read last cycle against the held word.
	assign hit      = pv_q && (rdata == w_q);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		held_d    = held_q;
		i_d       = i_q;
		e_d       = e_q;
		kept_d    = kept_q;
		removed_d = removed_q;
		pv_d      = 1'b0;
		op_d      = op_q;
		w_d       = w_q;
		res_d     = res_q;
		rd_en     = 1'b0;
		rd_addr   = i_q[IDX_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = held_q[IDX_W-1:0];
		wr_data   = w_q;
		load_out  = 1'b0;
		load_data = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d             = in_data.op;
					w_d              = w_in;
					i_d              = '0;
					kept_d           = '0;
					removed_d        = '0;
					res_d            = '0;
					res_d.status     = STAT_OK;
					res_d.last       = 1'b1;
					res_d.fill_count = 6'(held_q);
					unique case (in_data.op)
						OP_INSERT: begin
							if (held_q >= CNT_W'(CAPACITY)) begin
								res_d.status = STAT_FULL;
								state_d      = S_FIN;
							end else if (allow_q) begin
								wr_en            = 1'b1;
								wr_data          = w_in;
								held_d           = held_q + 1'b1;
								res_d.fill_count = 6'(held_q + 1'b1);
								state_d          = S_FIN;
							end else begin
								state_d = S_SCAN;
							end
						end
						OP_REMOVE: begin
							state_d = S_SCAN;
						end
						OP_SLICE: begin
							if (s_ext >= held_ext || e_clamp < s_ext) begin
								res_d.status = STAT_EMPTY;
								state_d      = S_FIN;
							end else begin
								i_d     = CNT_W'(s_ext);
								e_d     = CNT_W'(e_clamp);
								state_d = S_SL_RD;
							end
						end
						default: begin
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_SCAN: begin
				// Issue the next read while the previous entry is compared.
				if (i_q < held_q) begin
					rd_en = 1'b1;
					i_d   = i_nxt;
					pv_d  = 1'b1;
				end
				if (op_q == OP_INSERT) begin
					if (hit) begin
						res_d.status = STAT_DUP;
						pv_d         = 1'b0;
						state_d      = S_FIN;
					end else if (!pv_q && i_q == held_q) begin
						wr_en            = 1'b1;
						held_d           = held_q + 1'b1;
						res_d.fill_count = 6'(held_q + 1'b1);
						state_d          = S_FIN;
					end
				end else begin
					if (pv_q) begin
						if (hit && (allow_q || removed_q == '0)) begin
							removed_d = removed_q + 1'b1;
						end else begin
							// Compact: move the kept entry down to the next free slot.
							wr_en   = 1'b1;
							wr_addr = kept_q[IDX_W-1:0];
							wr_data = rdata;
							kept_d  = kept_q + 1'b1;
						end
					end else if (i_q == held_q) begin
						held_d              = kept_q;
						res_d.removed_count = 6'(removed_q);
						res_d.fill_count    = 6'(kept_q);
						state_d             = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					load_out  = 1'b1;
					load_data = res_q;
					state_d   = S_IDLE;
				end
			end
			S_SL_RD: begin
				rd_en   = 1'b1;
				state_d = S_SL_OUT;
			end
			S_SL_OUT: begin
				if (out_free) begin
					load_out             = 1'b1;
					load_data.status     = STAT_OK;
					load_data.out_word   = rd_wide[31:0];
					load_data.out_index  = 6'(i_q);
					load_data.word_valid = 1'b1;
					load_data.fill_count = 6'(held_q);
					load_data.last       = (i_q == e_q);
					if (i_q == e_q) begin
						state_d = S_IDLE;
					end else begin
						i_d     = i_nxt;
						rd_en   = 1'b1;
						rd_addr = i_nxt[IDX_W-1:0];
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			held_q      <= '0;
			allow_q     <= 1'b1;
			pv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
			pv_q    <= pv_d;
			if (cfg_wen) begin
				allow_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q       <= i_d;
		e_q       <= e_d;
		kept_q    <= kept_d;
		removed_q <= removed_d;
		op_q      <= op_d;
		w_q       <= w_d;
		res_q     <= res_d;
		if (load_out) begin
			out_q <= load_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_HOLDS(a_held_bound, clk, arst_n, held_q <= CNT_W'(CAPACITY), "fill count beyond capacity")
	`ASSERT_HOLDS(a_scan_books, clk, arst_n, (state_q == S_SCAN && op_q == OP_REMOVE) |-> ((kept_q + removed_q + CNT_W'(pv_q)) == i_q), "remove scan lost track of entries")
	`ASSERT_NEVER(a_slice_status, clk, arst_n, out_valid_q && out_q.word_valid && (out_q.status != STAT_OK || out_q.removed_count != '0), "slice entry with bad status")
	`ASSERT_HOLDS(a_not_last, clk, arst_n, (out_valid_q && !out_q.last) |-> (state_q == S_SL_OUT), "non-final result outside slice readout")

endmodule
